[design/bcs_pkg.sv]
package bcs_pkg;

    localparam int ChanW    = 3;
    localparam int ByteW    = 8;
    localparam int InDataW  = 8;
    localparam int OutDataW = 24;
    localparam int CfgIdxW  = 3;
    localparam int FifoDepth = 4;

    localparam logic [ByteW-1:0] HoldMax = 8'hFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOP_CHAN           = 3'd0,
        CFG_FALLBACK_CHAN      = 3'd1,
        CFG_STORED_CHANNEL     = 3'd2,
        CFG_LONG_PRESS_TICKS   = 3'd3,
        CFG_APPLY_DELAY_TICKS  = 3'd4,
        CFG_RELAY_SWITCH_POINT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [ChanW-1:0] top_chan;
        logic [ChanW-1:0] fallback_chan;
        logic [ByteW-1:0] stored_channel;
        logic [ByteW-1:0] long_press_ticks;
        logic [ByteW-1:0] apply_delay_ticks;
        logic [ByteW-1:0] relay_switch_point;
    } cfg_t;

    // segments in the low bits
    typedef struct packed {
        logic [ChanW-1:0] save_channel;
        logic             save_request;
        logic             refresh;
        logic             mute_led;
        logic [ByteW-1:0] relays;
        logic [ByteW-1:0] segments;
    } result_t;

    localparam int ResultW = $bits(result_t);

    function automatic logic [ByteW-1:0] seg_pattern(input logic [ChanW-1:0] ch);
        logic [ByteW-1:0] pat;
        unique case (ch)
            3'd0: pat = 8'h06;
            3'd1: pat = 8'h5B;
            3'd2: pat = 8'h4F;
            3'd3: pat = 8'h66;
            3'd4: pat = 8'h6D;
            3'd5: pat = 8'h7D;
            3'd6: pat = 8'h07;
            3'd7: pat = 8'h7F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

[design/bcs_core.sv]
module bcs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              level,
    input  bcs_pkg::cfg_t     cfg,
    output bcs_pkg::result_t  result
);
    import bcs_pkg::*;

    logic             started_reg,  started_next;
    logic [ChanW-1:0] channel_reg,  channel_next;
    logic [ByteW-1:0] relay_reg,    relay_next;
    logic             muted_reg,    muted_next;
    logic             last_reg,     last_next;
    logic [ByteW-1:0] hold_reg,     hold_next;
    logic [ByteW-1:0] count_reg,    count_next;

    logic [ChanW:0]   advanced;
    logic [ByteW-1:0] cd_cur;
    logic             refresh;
    logic             save;

    always_comb
    begin
        started_next = started_reg;
        channel_next = channel_reg;
        relay_next   = relay_reg;
        muted_next   = muted_reg;
        last_next    = level;
        hold_next    = hold_reg;
        count_next   = count_reg;
        refresh      = 1'b0;
        save         = 1'b0;
        advanced     = {1'b0, channel_reg} + 1'b1;
        cd_cur       = count_reg;
        if (!started_reg)
        begin
            started_next = 1'b1;
            hold_next    = '0;
            muted_next   = 1'b0;
            if (cfg.stored_channel > {{(ByteW-ChanW){1'b0}}, cfg.top_chan})
                channel_next = cfg.fallback_chan;
            else
                channel_next = cfg.stored_channel[ChanW-1:0];
            relay_next = ByteW'(1) << channel_next;
            refresh    = 1'b1;
        end
        else
        begin
            if (!last_reg && level)
            begin
                if (hold_reg <= cfg.long_press_ticks)
                begin
                    if (advanced > {1'b0, cfg.top_chan})
                        channel_next = '0;
                    else
                        channel_next = advanced[ChanW-1:0];
                    cd_cur  = cfg.apply_delay_ticks;
                    refresh = 1'b1;
                end
                hold_next = '0;
            end
            if (!level)
            begin
                if (hold_reg != HoldMax)
                    hold_next = hold_reg + 1'b1;
                if (hold_next == cfg.long_press_ticks)
                begin
                    muted_next = !muted_reg;
                    refresh    = 1'b1;
                end
            end
            if (cd_cur == cfg.relay_switch_point)
            begin
                relay_next = ByteW'(1) << channel_next;
                muted_next = 1'b0;
                refresh    = 1'b1;
            end
            else if (cd_cur == ByteW'(1))
            begin
                save = 1'b1;
            end
            if (cd_cur != '0)
                count_next = cd_cur - 1'b1;
            else
                count_next = cd_cur;
        end
    end

    always_comb
    begin
        result.segments     = seg_pattern(channel_next);
        result.relays       = muted_next ? '0 : relay_next;
        result.mute_led     = muted_next;
        result.refresh      = refresh;
        result.save_request = save;
        result.save_channel = save ? channel_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            channel_reg <= '0;
            relay_reg   <= '0;
            muted_reg   <= 1'b0;
            last_reg    <= 1'b1;
            hold_reg    <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            started_reg <= started_next;
            channel_reg <= channel_next;
            relay_reg   <= relay_next;
            muted_reg   <= muted_next;
            last_reg    <= last_next;
            hold_reg    <= hold_next;
            count_reg   <= count_next;
        end
    end

endmodule

[design/button_channel_selector_with_mute.sv]
// Button channel selector with mute.
// Input stream s_axis_*: one transfer per 50 ms tick, tdata[0] is the button
// level (0 pressed, 1 released). Output stream m_axis_*: exactly one result
// transfer per input transfer, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index (register number) and
// cfg_data; always ready, write only while the stream is idle.
// Each input is held in the input register, then its result is written into
// a 4-entry result queue; one tick per cycle is accepted while s_axis_tready
// is high. The state update is a single pass from input register to queue.
// s_axis_tready drops only when the queue plus the input register hold four
// items, so a stalled receiver backs up into the sender without loss.
// Reset: state cleared, last level released, configuration registers take
// their defaults (max 5, default 0, stored 0, long press 20, delay 40,
// switch point 30). The first tick after reset loads the channel.
module button_channel_selector_with_mute (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bcs_pkg::InDataW-1:0]   s_axis_tdata,   // [0] button_level
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] segments, [15:8] relays, [16] mute_led, [17] refresh,
    // [18] save_request, [21:19] save_channel
    output logic [bcs_pkg::OutDataW-1:0]  m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bcs_pkg::ByteW-1:0]     cfg_data
);
    import bcs_pkg::*;

    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = PtrW + 1;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic    level_reg;
    result_t result;
    result_t fifo_reg [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic in_xfer;
    logic out_xfer;

    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg + CntW'(in_valid_reg)) < CntW'(FifoDepth);
    assign m_axis_tvalid = count_reg != '0;
    assign m_axis_tdata  = {{(OutDataW-ResultW){1'b0}}, fifo_reg[rd_ptr_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_chan           <= 3'd5;
            cfg_reg.fallback_chan      <= 3'd0;
            cfg_reg.stored_channel     <= 8'd0;
            cfg_reg.long_press_ticks   <= 8'd20;
            cfg_reg.apply_delay_ticks  <= 8'd40;
            cfg_reg.relay_switch_point <= 8'd30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOP_CHAN:           cfg_reg.top_chan           <= cfg_data[ChanW-1:0];
                CFG_FALLBACK_CHAN:      cfg_reg.fallback_chan      <= cfg_data[ChanW-1:0];
                CFG_STORED_CHANNEL:     cfg_reg.stored_channel     <= cfg_data;
                CFG_LONG_PRESS_TICKS:   cfg_reg.long_press_ticks   <= cfg_data;
                CFG_APPLY_DELAY_TICKS:  cfg_reg.apply_delay_ticks  <= cfg_data;
                CFG_RELAY_SWITCH_POINT: cfg_reg.relay_switch_point <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            level_reg <= s_axis_tdata[0];
    end

    bcs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_valid_reg),
        .level  (level_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_comb
    begin
        count_next = count_reg;
        if (in_valid_reg && !out_xfer)
            count_next = count_reg + 1'b1;
        else if (!in_valid_reg && out_xfer)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            fifo_reg[wr_ptr_reg] <= result;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcs_pkg::*;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CfgIdxW-1:0] idx;
        logic [ByteW-1:0]   val;
        logic               level;
        logic               typed;
        result_t            want;
    } row_t;

    localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_TICKS  = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    // digit patterns for channel 0..7 (shown as 1..8), channel 0 in the low byte
    localparam logic [63:0] DIGIT_ROM = {
        8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [ByteW-1:0]    cfg_data = '0;

    button_channel_selector_with_mute dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // selector model: configuration and state
    cfg_t       sel_cfg = '{top_chan: 3'd5, fallback_chan: 3'd0, stored_channel: 8'd0,
                            long_press_ticks: 8'd20, apply_delay_ticks: 8'd40,
                            relay_switch_point: 8'd30};
    logic       began = 1'b0;
    logic [2:0] chan = 3'd0;
    logic [7:0] relay_pat = 8'd0;
    logic       muted_q = 1'b0;
    logic       prev_level = 1'b1;
    logic [7:0] hold = 8'd0;
    logic [7:0] cdown = 8'd0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    bit      calm = 1'b0;

    row_t plan [34] = '{
        '{ROW_WRITE, CFG_TOP_CHAN,           8'hFA, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_FALLBACK_CHAN,      8'h06, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_STORED_CHANNEL,     8'hC8, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_LONG_PRESS_TICKS,   8'h03, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_APPLY_DELAY_TICKS,  8'h04, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_RELAY_SWITCH_POINT, 8'h02, 1'b0, 1'b0, '0},
        // first tick: stored above max, default 6 used
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b1,
          result_t'{3'd0, 1'b0, 1'b1, 1'b0, 8'h40, 8'h07}},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},   // advance wraps to 0
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},   // relay switch
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b1,
          result_t'{3'd0, 1'b1, 1'b0, 1'b0, 8'h01, 8'h06}},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},   // mute on
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},   // long release, no advance
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},   // switch clears mute
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_WRITE, CFG_RELAY_SWITCH_POINT, 8'h01, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_APPLY_DELAY_TICKS,  8'h03, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_SPARE_LO,           8'hFF, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0},   // switch at 1, no save
        '{ROW_WRITE, CFG_RELAY_SWITCH_POINT, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_WRITE, CFG_LONG_PRESS_TICKS,   8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_TOP_CHAN, 8'h00, 1'b1, 1'b0, '0}
    };

    function automatic result_t tick_result(input logic level);
        result_t r;
        logic    refresh;
        logic    save;
        int      nxt;
        refresh = 1'b0;
        save = 1'b0;
        if (!began)
        begin
            began = 1'b1;
            prev_level = level;
            hold = 8'd0;
            muted_q = 1'b0;
            if (sel_cfg.stored_channel > sel_cfg.top_chan)
                chan = sel_cfg.fallback_chan;
            else
                chan = sel_cfg.stored_channel[2:0];
            relay_pat = 8'd1 << chan;
            refresh = 1'b1;
        end
        else
        begin
            if (!prev_level && level)
            begin
                if (hold <= sel_cfg.long_press_ticks)
                begin
                    nxt = int'(chan) + 1;
                    if (nxt > int'(sel_cfg.top_chan))
                        nxt = 0;
                    chan = nxt[2:0];
                    cdown = sel_cfg.apply_delay_ticks;
                    refresh = 1'b1;
                end
                hold = 8'd0;
            end
            if (!level)
            begin
                if (hold != HoldMax)
                    hold = hold + 8'd1;
                if (hold == sel_cfg.long_press_ticks)
                begin
                    muted_q = !muted_q;
                    refresh = 1'b1;
                end
            end
            prev_level = level;
            if (cdown == sel_cfg.relay_switch_point)
            begin
                relay_pat = 8'd1 << chan;
                muted_q = 1'b0;
                refresh = 1'b1;
            end
            else if (cdown == 8'd1)
                save = 1'b1;
            if (cdown != 8'd0)
                cdown = cdown - 8'd1;
        end
        r.segments = DIGIT_ROM[chan*8 +: 8];
        r.relays = muted_q ? 8'd0 : relay_pat;
        r.mute_led = muted_q;
        r.refresh = refresh;
        r.save_request = save;
        r.save_channel = save ? chan : 3'd0;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ERROR %s", $time, msg);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TOP_CHAN:           sel_cfg.top_chan = val[2:0];
            CFG_FALLBACK_CHAN:      sel_cfg.fallback_chan = val[2:0];
            CFG_STORED_CHANNEL:     sel_cfg.stored_channel = val;
            CFG_LONG_PRESS_TICKS:   sel_cfg.long_press_ticks = val;
            CFG_APPLY_DELAY_TICKS:  sel_cfg.apply_delay_ticks = val;
            CFG_RELAY_SWITCH_POINT: sel_cfg.relay_switch_point = val;
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic level, input logic typed, input result_t want);
        int      gap;
        result_t r;
        gap = idle_len();
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(InDataW-1){1'b0}}, level};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = tick_result(level);
        pending_results.push_back(typed ? want : r);
    endtask

    // stream idle and all results back before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_run(input logic level, input int len, inout int sent);
        repeat (len)
        begin
            send_tick(level, 1'b0, '0);
            sent++;
        end
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            int gap;
            gap = idle_len();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report("result transfer with no tick pending");
            else
            begin
                want = pending_results.pop_front();
                got = result_t'(m_axis_tdata[ResultW-1:0]);
                if (got.segments !== want.segments)
                    report($sformatf("segments %h, expected %h", got.segments, want.segments));
                if (got.relays !== want.relays)
                    report($sformatf("relays %h, expected %h", got.relays, want.relays));
                if (got.mute_led !== want.mute_led)
                    report($sformatf("mute_led %b, expected %b", got.mute_led, want.mute_led));
                if (got.refresh !== want.refresh)
                    report($sformatf("refresh %b, expected %b", got.refresh, want.refresh));
                if (got.save_request !== want.save_request)
                    report($sformatf("save_request %b, expected %b",
                                     got.save_request, want.save_request));
                if (got.save_channel !== want.save_channel)
                    report($sformatf("save_channel %0d, expected %0d",
                                     got.save_channel, want.save_channel));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [ByteW-1:0] r_max;
        logic [ByteW-1:0] r_def;
        logic [ByteW-1:0] r_sto;
        logic [ByteW-1:0] r_lpt;
        logic [ByteW-1:0] r_apd;
        logic [ByteW-1:0] r_sw;
        int               sent;
        int               len;
        int               lpt;
        bit               last_tick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last_tick = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (last_tick)
                    settle();
                write_reg(plan[i].idx, plan[i].val);
                last_tick = 1'b0;
            end
            else
            begin
                send_tick(plan[i].level, plan[i].typed, plan[i].want);
                last_tick = 1'b1;
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            calm = (p == 5);
            case (p)
                0:
                begin
                    r_max = 8'd5; r_def = 8'd0; r_sto = 8'd0;
                    r_lpt = 8'd20; r_apd = 8'd40; r_sw = 8'd30;
                end
                1:
                begin
                    r_max = 8'd7; r_def = 8'd7; r_sto = 8'hFF;
                    r_lpt = 8'd1; r_apd = 8'd1; r_sw = 8'd1;
                end
                2:
                begin
                    r_max = 8'd0; r_def = 8'd0; r_sto = 8'd0;
                    r_lpt = 8'hFF; r_apd = 8'hFF; r_sw = 8'hFF;
                end
                3:
                begin
                    r_max = 8'($urandom_range(0, 255)); r_def = 8'($urandom_range(0, 255));
                    r_sto = 8'($urandom_range(0, 255));
                    r_lpt = 8'd0; r_apd = 8'd2; r_sw = 8'd0;
                end
                default:
                begin
                    r_max = 8'($urandom_range(0, 255)); r_def = 8'($urandom_range(0, 255));
                    r_sto = 8'($urandom_range(0, 255));
                    r_lpt = 8'($urandom_range(1, 30)); r_apd = 8'($urandom_range(1, 60));
                    r_sw = 8'($urandom_range(0, r_apd));
                end
            endcase
            write_reg(CFG_TOP_CHAN, r_max);
            write_reg(CFG_FALLBACK_CHAN, r_def);
            write_reg(CFG_STORED_CHANNEL, r_sto);
            write_reg(CFG_LONG_PRESS_TICKS, r_lpt);
            write_reg(CFG_APPLY_DELAY_TICKS, r_apd);
            write_reg(CFG_RELAY_SWITCH_POINT, r_sw);
            if (p >= 4)
                write_reg(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom_range(0, 255)));

            sent = 0;
            lpt = int'(sel_cfg.long_press_ticks);
            while (sent < PHASE_TICKS)
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    // noise
                    repeat ($urandom_range(1, 4))
                    begin
                        send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
                        sent++;
                    end
                end
                else
                begin
                    // press then release
                    if (lpt == 0)
                        len = $urandom_range(1, 4);
                    else if (lpt > 60 && $urandom_range(0, 9) != 0)
                        len = $urandom_range(1, 8);
                    else
                        case ($urandom_range(0, 2))
                            0: len = $urandom_range(1, lpt);
                            1: len = lpt;
                            default: len = lpt + $urandom_range(1, 4);
                        endcase
                    send_run(1'b0, len, sent);
                    if ($urandom_range(0, 9) < 7)
                        len = $urandom_range(1, 4);
                    else
                        len = $urandom_range(1, int'(sel_cfg.apply_delay_ticks) + 2);
                    send_run(1'b1, len, sent);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
